FILE: src/ipmrs_pkg.sv
// Shared types, operation codes and the register reset table of the PMIC register slave.
package ipmrs_pkg;

    localparam logic [1:0] OP_START_WRITE = 2'd0;
    localparam logic [1:0] OP_WRITE_BYTE  = 2'd1;
    localparam logic [1:0] OP_READ_BYTE   = 2'd2;

    localparam logic [7:0] ONOFF_ADDR      = 8'h41;
    localparam logic [7:0] CLEAR_ON_READ_A = 8'h0B;
    localparam logic [7:0] CLEAR_ON_READ_B = 8'h0C;
    localparam int         SOFT_RESET_BIT  = 7;
    localparam int         POWER_OFF_BIT   = 1;

    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [7:0] addr;
        logic [7:0] wdata;
        logic       rst_req;
        logic       shut_req;
        logic       bad;
    } access_t;

    function automatic logic [7:0] reset_value(input logic [7:0] addr);
        logic [7:0] v;
        v = 8'h00;
        case (addr)
            8'h00: v = 8'h12;
            8'h01: v = 8'h03;
            8'h03: v = 8'h4C;
            8'h04: v = 8'h41;
            8'h0C: v = 8'h40;
            8'h0D: v = 8'h75;
            8'h0F, 8'h10, 8'h11: v = 8'hFF;
            8'h13: v = 8'h10;
            8'h1B: v = 8'h20;
            8'h1C: v = 8'h10;
            8'h22: v = 8'h07;
            8'h42: v = 8'h07;
            default:
            begin
                if ((addr >= 8'h1D && addr <= 8'h20) || (addr >= 8'h23 && addr <= 8'h34))
                begin
                    v = 8'h40;
                end
            end
        endcase
        return v;
    endfunction

endpackage

FILE: src/ipmrs_req_if.sv
// Request channel carrying one bus event transaction into the register slave.
interface ipmrs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

FILE: src/ipmrs_rsp_if.sv
// Response channel carrying one result transaction out of the register slave.
interface ipmrs_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       reset_request;
    logic       shutdown_request;
    logic       bad_address;

    modport source (output valid, output read_data, output reset_request,
                    output shutdown_request, output bad_address, input ready);
    modport sink (input valid, input read_data, input reset_request,
                  input shutdown_request, input bad_address, output ready);
endinterface

FILE: src/i2c_pmic_register_slave_top.sv
// Top level of the byte-level PMIC register slave with auto-increment pointer.
//
// The req channel takes one bus event per transaction: operation selects start
// of write, write byte or read byte, and data_byte carries the master's byte.
// The rsp channel returns exactly one result transaction per request, in order,
// with read_data, reset_request, shutdown_request and bad_address.
// A response becomes valid once its result is registered: the bank read is
// registered at acceptance, and the result after it when the output is free.
// Throughput is one transaction per cycle while rsp.ready is high; pointer
// and bank updates take effect at the acceptance edge, so back-to-back
// accesses see each other's writes.
// Reset clears the pointer to empty and marks every register as holding its
// reset value; the block accepts requests in the first cycle after reset.
// When the receiver stalls, up to two results are held inside, after which
// req.ready falls until rsp.ready returns.
module i2c_pmic_register_slave_top
    import ipmrs_pkg::*;
#(
    parameter int REGISTER_COUNT = 91
)
(
    input  logic           clk,
    input  logic           rst_n,
    ipmrs_req_if.sink      req,
    ipmrs_rsp_if.source    rsp
);

    access_t    access;
    logic       accept;
    logic [7:0] mem_data;
    logic       mem_written;

    logic       a_valid_reg;
    logic       a_rd_reg;
    logic [7:0] a_addr_reg;
    logic       a_rst_reg;
    logic       a_shut_reg;
    logic       a_bad_reg;
    logic       b_valid_reg;
    logic [7:0] b_data_reg;
    logic       b_rst_reg;
    logic       b_shut_reg;
    logic       b_bad_reg;
    logic       b_load;
    logic [7:0] a_data;

    assign b_load = a_valid_reg && (!b_valid_reg || rsp.ready);
    assign req.ready = !a_valid_reg || b_load;
    assign accept = req.valid && req.ready;

    ipmrs_pointer #(.REGISTER_COUNT(REGISTER_COUNT)) u_pointer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (req.operation),
        .data_byte (req.data_byte),
        .access    (access)
    );

    ipmrs_regbank #(.REGISTER_COUNT(REGISTER_COUNT)) u_regbank
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .access      (access),
        .mem_data    (mem_data),
        .mem_written (mem_written)
    );

    always_comb
    begin
        a_data = 8'h00;
        if (a_rd_reg)
        begin
            a_data = mem_written ? mem_data : reset_value(a_addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_rd_reg <= access.rd;
            a_addr_reg <= access.addr;
            a_rst_reg <= access.rst_req;
            a_shut_reg <= access.shut_req;
            a_bad_reg <= access.bad;
        end
        if (b_load)
        begin
            b_data_reg <= a_data;
            b_rst_reg <= a_rst_reg;
            b_shut_reg <= a_shut_reg;
            b_bad_reg <= a_bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_load)
            begin
                a_valid_reg <= 1'b0;
            end
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid = b_valid_reg;
    assign rsp.read_data = b_data_reg;
    assign rsp.reset_request = b_rst_reg;
    assign rsp.shutdown_request = b_shut_reg;
    assign rsp.bad_address = b_bad_reg;

endmodule

FILE: src/ipmrs_pointer.sv
// Register pointer with auto-increment and decode of one bus event into a bank access.
module ipmrs_pointer
    import ipmrs_pkg::*;
#(
    parameter int REGISTER_COUNT = 91
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [1:0] operation,
    input  logic [7:0] data_byte,
    output access_t    access
);

    localparam logic [8:0] COUNT = 9'(REGISTER_COUNT);

    logic [7:0] ptr_value_reg;
    logic [7:0] ptr_value_next;
    logic       ptr_valid_reg;
    logic       ptr_valid_next;
    logic [7:0] addr;
    logic       in_range;
    logic [8:0] inc;

    always_comb
    begin
        addr = ptr_valid_reg ? ptr_value_reg : 8'h00;
        in_range = {1'b0, addr} < COUNT;
        inc = {1'b0, addr} + 9'd1;
        for (int k = 0; k < 4; k++)
        begin
            if (inc >= COUNT)
            begin
                inc = inc - COUNT;
            end
        end

        access = '0;
        access.addr = addr;
        ptr_value_next = ptr_value_reg;
        ptr_valid_next = ptr_valid_reg;

        case (operation)
            OP_START_WRITE:
            begin
                ptr_valid_next = 1'b0;
            end
            OP_WRITE_BYTE:
            begin
                if (!ptr_valid_reg)
                begin
                    ptr_value_next = data_byte;
                    ptr_valid_next = 1'b1;
                end
                else
                begin
                    ptr_valid_next = 1'b0;
                    access.wr = in_range;
                    access.wdata = data_byte;
                    access.bad = !in_range;
                    if (in_range && addr == ONOFF_ADDR)
                    begin
                        access.rst_req = data_byte[SOFT_RESET_BIT];
                        access.shut_req = !data_byte[SOFT_RESET_BIT] && data_byte[POWER_OFF_BIT];
                    end
                end
            end
            OP_READ_BYTE:
            begin
                ptr_valid_next = 1'b1;
                ptr_value_next = inc[7:0];
                access.rd = in_range;
                access.bad = !in_range;
                access.wr = in_range && (addr == CLEAR_ON_READ_A || addr == CLEAR_ON_READ_B);
                access.wdata = 8'h00;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_value_reg <= 8'h00;
            ptr_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            ptr_value_reg <= ptr_value_next;
            ptr_valid_reg <= ptr_valid_next;
        end
    end

endmodule

FILE: src/ipmrs_regbank.sv
// Register bank memory with per-entry written flags and a registered read port.
module ipmrs_regbank
    import ipmrs_pkg::*;
#(
    parameter int REGISTER_COUNT = 91
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  access_t    access,
    output logic [7:0] mem_data,
    output logic       mem_written
);

    localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    logic [7:0]                mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] written_reg;
    logic [7:0]                mem_data_reg;
    logic                      mem_written_reg;
    logic [IDX_W-1:0]          idx;

    assign idx = access.addr[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && access.rd)
        begin
            mem_data_reg <= mem[idx];
        end
        if (accept && access.wr)
        begin
            mem[idx] <= access.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            mem_written_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (access.rd)
            begin
                mem_written_reg <= written_reg[idx];
            end
            if (access.wr)
            begin
                written_reg[idx] <= 1'b1;
            end
        end
    end

    assign mem_data = mem_data_reg;
    assign mem_written = mem_written_reg;

endmodule
